FILE: rtl/tdtm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdtm_pkg;

  // fixed field widths of the event and report records
  localparam int unsigned TASK_W  = 3;
  localparam int unsigned STAMP_W = 48;
  localparam int unsigned DLINE_W = 32;
  localparam int unsigned CNT_W   = 32;

  // event kind codes on the op port
  localparam logic [1:0] OP_RELEASE = 2'd0;
  localparam logic [1:0] OP_START   = 2'd1;
  localparam logic [1:0] OP_FINISH  = 2'd2;

  // classified request kind; blank is a slot outside the table
  typedef enum logic [2:0] {
    CMD_RELEASE = 3'd0,
    CMD_START   = 3'd1,
    CMD_FINISH  = 3'd2,
    CMD_REPORT  = 3'd3,
    CMD_BLANK   = 3'd4
  } cmd_kind_e;

  // classified request, front to back
  typedef struct packed {
    cmd_kind_e            kind;
    logic [TASK_W-1:0]    task_id;
    logic [STAMP_W-1:0]   timestamp;
    logic [DLINE_W-1:0]   deadline;
    logic                 hard;
  } cmd_t;

  // statistics report of one slot
  typedef struct packed {
    logic [TASK_W-1:0]  task_out;
    logic [CNT_W-1:0]   release_count;
    logic [CNT_W-1:0]   start_count;
    logic [CNT_W-1:0]   finish_count;
    logic [CNT_W-1:0]   hard_miss_count;
    logic [CNT_W-1:0]   soft_miss_count;
    logic [STAMP_W-1:0] max_latency;
    logic [STAMP_W-1:0] max_exec;
    logic [STAMP_W-1:0] max_response;
    logic               missed_now;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/tdtm_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// two-entry first-in first-out queue
module tdtm_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  // handshake
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tdtm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module tdtm_front #(
  parameter int unsigned NUM_TASKS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  output logic                               full_o,
  input  wire logic [1:0]                    op_i,
  input  wire logic [tdtm_pkg::TASK_W-1:0]   task_id_i,
  input  wire logic [tdtm_pkg::STAMP_W-1:0]  timestamp_i,
  input  wire logic [tdtm_pkg::DLINE_W-1:0]  deadline_i,
  input  wire logic                          hard_i,
  input  wire logic                          cmd_pop_i,
  output logic                               cmd_empty_o,
  output tdtm_pkg::cmd_t                     cmd_o
);

  tdtm_pkg::cmd_t cmd_in;
  logic [$bits(tdtm_pkg::cmd_t)-1:0] cmd_raw;

  // classify the event: slot range first, then event kind
  always_comb begin
    cmd_in.task_id   = task_id_i;
    cmd_in.timestamp = timestamp_i;
    cmd_in.deadline  = deadline_i;
    cmd_in.hard      = hard_i;
    if (32'(task_id_i) >= 32'(NUM_TASKS)) begin
      cmd_in.kind = tdtm_pkg::CMD_BLANK;
    end else begin
      case (op_i)
        tdtm_pkg::OP_RELEASE: cmd_in.kind = tdtm_pkg::CMD_RELEASE;
        tdtm_pkg::OP_START:   cmd_in.kind = tdtm_pkg::CMD_START;
        tdtm_pkg::OP_FINISH:  cmd_in.kind = tdtm_pkg::CMD_FINISH;
        default:              cmd_in.kind = tdtm_pkg::CMD_REPORT;
      endcase
    end
  end

  // request queue toward the back part
  tdtm_queue #(
    .WIDTH($bits(tdtm_pkg::cmd_t))
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_raw),
    .empty_o (cmd_empty_o)
  );

  assign cmd_o = tdtm_pkg::cmd_t'(cmd_raw);

endmodule

`default_nettype wire

FILE: rtl/tdtm_back.sv
`timescale 1ns / 1ps
`default_nettype none

module tdtm_back #(
  parameter int unsigned NUM_TASKS = 8,
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_empty_i,
  input  tdtm_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  input  wire logic           res_full_i,
  output logic                res_push_o,
  output tdtm_pkg::res_t      res_o
);

  localparam int unsigned IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  // per-slot timing record
  typedef struct packed {
    logic [tdtm_pkg::CNT_W-1:0] releases;
    logic [tdtm_pkg::CNT_W-1:0] starts;
    logic [tdtm_pkg::CNT_W-1:0] finishes;
    logic [tdtm_pkg::CNT_W-1:0] hard_misses;
    logic [tdtm_pkg::CNT_W-1:0] soft_misses;
    logic [TIME_BITS-1:0]       last_release;
    logic [TIME_BITS-1:0]       last_start;
    logic [TIME_BITS-1:0]       worst_latency;
    logic [TIME_BITS-1:0]       worst_exec;
    logic [TIME_BITS-1:0]       worst_response;
  } rec_t;

  // positive difference larger than the worst so far raises it
  function automatic logic [TIME_BITS-1:0] raise_worst(
    input logic [TIME_BITS-1:0] worst,
    input logic [TIME_BITS-1:0] now,
    input logic [TIME_BITS-1:0] then_t
  );
    logic [TIME_BITS-1:0] diff;
    diff = now - then_t;
    if ((now > then_t) && (diff > worst)) begin
      return diff;
    end
    return worst;
  endfunction

  state_e               state_q, state_d;
  tdtm_pkg::cmd_t       cmd_q;
  rec_t                 mem_q [NUM_TASKS];
  rec_t                 rd_q;
  logic                 rd_vld_q;
  logic [NUM_TASKS-1:0] vld_q;
  logic [IDX_W-1:0]     rd_idx, wr_idx;
  rec_t                 cur, nxt;
  logic [TIME_BITS-1:0] t_now, rsp;
  logic                 late, missed, wr_en;

  assign rd_idx     = IDX_W'(cmd_i.task_id);
  assign wr_idx     = IDX_W'(cmd_q.task_id);
  assign cmd_pop_o  = (state_q == ST_IDLE) && !cmd_empty_i && !res_full_i;
  assign res_push_o = (state_q == ST_EXEC);

  // sequencer: fetch the record, then update and report
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_pop_o) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      vld_q   <= '0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        vld_q[wr_idx] <= 1'b1;
      end
    end
  end

  // record memory: registered read on fetch, write on update
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      rd_q     <= mem_q[rd_idx];
      rd_vld_q <= vld_q[rd_idx];
      cmd_q    <= cmd_i;
    end
    if (wr_en) begin
      mem_q[wr_idx] <= nxt;
    end
  end

  // never-written slots read as zero
  assign cur   = rd_vld_q ? rd_q : '0;
  assign t_now = TIME_BITS'(cmd_q.timestamp);
  assign rsp   = t_now - cur.last_release;
  assign late  = (t_now > cur.last_release) && (rsp > TIME_BITS'(cmd_q.deadline));

  // record update for the event kind
  always_comb begin
    nxt    = cur;
    missed = 1'b0;
    wr_en  = 1'b0;
    case (cmd_q.kind)
      tdtm_pkg::CMD_RELEASE: begin
        wr_en            = res_push_o;
        nxt.releases     = cur.releases + tdtm_pkg::CNT_W'(1);
        nxt.last_release = t_now;
      end
      tdtm_pkg::CMD_START: begin
        wr_en             = res_push_o;
        nxt.starts        = cur.starts + tdtm_pkg::CNT_W'(1);
        nxt.last_start    = t_now;
        nxt.worst_latency = raise_worst(cur.worst_latency, t_now, cur.last_release);
      end
      tdtm_pkg::CMD_FINISH: begin
        wr_en              = res_push_o;
        nxt.finishes       = cur.finishes + tdtm_pkg::CNT_W'(1);
        nxt.worst_exec     = raise_worst(cur.worst_exec, t_now, cur.last_start);
        nxt.worst_response = raise_worst(cur.worst_response, t_now, cur.last_release);
        missed             = late;
        if (late && cmd_q.hard) begin
          nxt.hard_misses = cur.hard_misses + tdtm_pkg::CNT_W'(1);
        end else if (late) begin
          nxt.soft_misses = cur.soft_misses + tdtm_pkg::CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // report; a slot outside the table reports zeros
  always_comb begin
    res_o          = '0;
    res_o.task_out = cmd_q.task_id;
    if (cmd_q.kind != tdtm_pkg::CMD_BLANK) begin
      res_o.release_count   = nxt.releases;
      res_o.start_count     = nxt.starts;
      res_o.finish_count    = nxt.finishes;
      res_o.hard_miss_count = nxt.hard_misses;
      res_o.soft_miss_count = nxt.soft_misses;
      res_o.max_latency     = tdtm_pkg::STAMP_W'(nxt.worst_latency);
      res_o.max_exec        = tdtm_pkg::STAMP_W'(nxt.worst_exec);
      res_o.max_response    = tdtm_pkg::STAMP_W'(nxt.worst_response);
      res_o.missed_now      = missed;
    end
  end

`ifndef SYNTH
  // every fetched request is reported in the next cycle
  a_pop_then_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> res_push_o)
    else $error("request fetched without a report");

  // the report queue always has room when a report is made
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("report pushed into a full queue");

  // a deadline miss is only flagged on a finish
  a_miss_on_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.missed_now) |-> (cmd_q.kind == tdtm_pkg::CMD_FINISH))
    else $error("miss flagged on a non-finish event");
`endif

endmodule

`default_nettype wire

FILE: rtl/task_deadline_timing_monitor.sv
`timescale 1ns / 1ps
`default_nettype none

// Timing monitor for up to NUM_TASKS task slots. Each request is a release, start or finish
// event with a microsecond timestamp (and, on finish, a relative deadline and hard flag), or a
// report query; each returns one report with the slot's updated event counters, worst latency,
// worst execution and worst response time, and whether this finish missed its deadline. Both
// sides behave as queues: push while full is low, pop while empty is low. A two-entry request
// queue feeds the record engine and a two-entry report queue holds finished reports, so either
// side can stall on its own. The engine handles one event at a time: it reads the slot record
// from its memory into a register, then updates it, writes it back and pushes the report, and
// takes no new event until that report is made. Reset clears every slot at once through
// per-slot valid bits; no clearing pass is needed.
module task_deadline_timing_monitor #(
  parameter int unsigned NUM_TASKS = 8,
  parameter int unsigned TIME_BITS = 48
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [1:0]                    op_i,
  input  wire logic [tdtm_pkg::TASK_W-1:0]   task_id_i,
  input  wire logic [tdtm_pkg::STAMP_W-1:0]  timestamp_i,
  input  wire logic [tdtm_pkg::DLINE_W-1:0]  deadline_i,
  input  wire logic                          hard_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [tdtm_pkg::TASK_W-1:0]        task_out_o,
  output logic [tdtm_pkg::CNT_W-1:0]         release_count_o,
  output logic [tdtm_pkg::CNT_W-1:0]         start_count_o,
  output logic [tdtm_pkg::CNT_W-1:0]         finish_count_o,
  output logic [tdtm_pkg::CNT_W-1:0]         hard_miss_count_o,
  output logic [tdtm_pkg::CNT_W-1:0]         soft_miss_count_o,
  output logic [tdtm_pkg::STAMP_W-1:0]       max_latency_o,
  output logic [tdtm_pkg::STAMP_W-1:0]       max_exec_o,
  output logic [tdtm_pkg::STAMP_W-1:0]       max_response_o,
  output logic                               missed_now_o
);

  tdtm_pkg::cmd_t cmd;
  logic           cmd_empty, cmd_pop;
  tdtm_pkg::res_t res_in, res_out;
  logic [$bits(tdtm_pkg::res_t)-1:0] res_raw;
  logic           res_full, res_push;

  // front: classify and queue requests
  tdtm_front #(
    .NUM_TASKS(NUM_TASKS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .op_i        (op_i),
    .task_id_i   (task_id_i),
    .timestamp_i (timestamp_i),
    .deadline_i  (deadline_i),
    .hard_i      (hard_i),
    .cmd_pop_i   (cmd_pop),
    .cmd_empty_o (cmd_empty),
    .cmd_o       (cmd)
  );

  // back: per-slot record update
  tdtm_back #(
    .NUM_TASKS(NUM_TASKS),
    .TIME_BITS(TIME_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // report queue toward the consumer
  tdtm_queue #(
    .WIDTH($bits(tdtm_pkg::res_t))
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_raw),
    .empty_o (empty)
  );

  assign res_out           = tdtm_pkg::res_t'(res_raw);
  assign task_out_o        = res_out.task_out;
  assign release_count_o   = res_out.release_count;
  assign start_count_o     = res_out.start_count;
  assign finish_count_o    = res_out.finish_count;
  assign hard_miss_count_o = res_out.hard_miss_count;
  assign soft_miss_count_o = res_out.soft_miss_count;
  assign max_latency_o     = res_out.max_latency;
  assign max_exec_o        = res_out.max_exec;
  assign max_response_o    = res_out.max_response;
  assign missed_now_o      = res_out.missed_now;

endmodule

`default_nettype wire
